>>> design/kslpd_pkg.sv
// shared types and constants for the key short / long press detector
package kslpd_pkg;

  // number of key lines that take part in detection
  localparam int KEY_COUNT = 16;

  // width of the key bitmap ports
  localparam int KEY_W = 16;

  // width of the hold counter
  localparam int HOLD_W = 17;

  // width of the configuration data word
  localparam int CFG_DATA_W = 16;

  // width of the configuration register index
  localparam int CFG_INDEX_W = 2;

  // mask of the key lines in use
  localparam logic [KEY_W-1:0] KEY_MASK =
    KEY_W'((64'd1 << KEY_COUNT) - 64'd1);

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LONG_PRESS_ENABLE  = 2'd0,
    REG_LONG_PRESS_TICKS   = 2'd1,
    REG_HOLD_TIMEOUT_TICKS = 2'd2
  } cfg_reg_t;

  // press kind codes
  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  // reset values of the configuration registers
  localparam logic                  RESET_LONG_PRESS_ENABLE  = 1'b1;
  localparam logic [CFG_DATA_W-1:0] RESET_LONG_PRESS_TICKS   = 16'd100;
  localparam logic [CFG_DATA_W-1:0] RESET_HOLD_TIMEOUT_TICKS = 16'd1000;

endpackage

>>> design/key_short_long_press_detector.sv
// Key short / long press detector: one scan bitmap per item. Throughput is one item
// per clock cycle while the output is not stalled; an item is captured in the input
// register, then the press logic compares it against the held bitmap and hold
// counter and loads the result register, which also updates the state. An item
// gives at most one result; with long-press mode on, a release before the threshold
// reports a short press of the held keys, and a hold past the threshold reports one
// long press, rearmed on release. A hold past the timeout clears the counter. With
// long-press mode off, every new non-empty bitmap is reported as a short press.
// Configuration writes are always accepted and should be made while the block is idle.
module key_short_long_press_detector
  import kslpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [KEY_W-1:0]       pressed_keys,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KEY_W-1:0]       event_keys,
  output logic                   press_kind,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic                  long_press_enable;
  logic [CFG_DATA_W-1:0] long_press_ticks;
  logic [CFG_DATA_W-1:0] hold_timeout_ticks;

  // input register
  logic             s1_valid;
  logic [KEY_W-1:0] s1_keys;

  // detector state
  logic [KEY_W-1:0]  held_keys;
  logic [HOLD_W-1:0] hold_count;
  logic              long_reported;

  logic [KEY_W-1:0]  held_keys_next;
  logic [HOLD_W-1:0] hold_count_next;
  logic              long_reported_next;
  logic              emit;
  logic [KEY_W-1:0]  emit_keys;
  logic              emit_kind;
  logic [KEY_W-1:0]  keys;
  logic              advance;
  logic              fire;

  // handshake control
  assign advance   = !out_valid || out_ready;
  assign fire      = s1_valid && advance;
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_enable  <= RESET_LONG_PRESS_ENABLE;
      long_press_ticks   <= RESET_LONG_PRESS_TICKS;
      hold_timeout_ticks <= RESET_HOLD_TIMEOUT_TICKS;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_LONG_PRESS_ENABLE:  long_press_enable  <= cfg_data[0];
        REG_LONG_PRESS_TICKS:   long_press_ticks   <= cfg_data;
        REG_HOLD_TIMEOUT_TICKS: hold_timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_keys <= pressed_keys;
    end
  end

  // press detection for the item in the input register
  always_comb begin
    keys               = s1_keys & KEY_MASK;
    held_keys_next     = held_keys;
    hold_count_next    = hold_count;
    long_reported_next = long_reported;
    emit               = 1'b0;
    emit_keys          = held_keys;
    emit_kind          = KIND_SHORT;
    if (long_press_enable) begin
      if (hold_count > {1'b0, hold_timeout_ticks}) begin
        // timeout clears the counter only
        hold_count_next = '0;
      end else if (hold_count > {1'b0, long_press_ticks}) begin
        if (!long_reported) begin
          emit               = 1'b1;
          emit_kind          = KIND_LONG;
          long_reported_next = 1'b1;
        end else if (keys == '0) begin
          // release rearms the long press
          held_keys_next     = '0;
          hold_count_next    = '0;
          long_reported_next = 1'b0;
        end
      end else if (keys != held_keys) begin
        // release before the threshold is a short press
        if (keys == '0) begin
          emit = 1'b1;
        end
        held_keys_next  = keys;
        hold_count_next = '0;
      end else if (keys != '0) begin
        hold_count_next = hold_count + HOLD_W'(1);
      end
    end else begin
      // edge mode reports each new non-empty bitmap
      if (keys != held_keys) begin
        if (keys != '0) begin
          emit      = 1'b1;
          emit_keys = keys;
        end
        held_keys_next = keys;
      end
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      held_keys     <= '0;
      hold_count    <= '0;
      long_reported <= 1'b0;
    end else if (fire) begin
      held_keys     <= held_keys_next;
      hold_count    <= hold_count_next;
      long_reported <= long_reported_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      event_keys <= emit_keys;
      press_kind <= emit_kind;
    end
  end

  // a long press leaves the long-reported flag set
  a_long_sets_flag: assert property (@(posedge clk) disable iff (rst)
    fire && emit && emit_kind == KIND_LONG |=> long_reported)
    else $error("long press reported without setting the flag");

  // long presses come only from long-press mode
  a_long_needs_mode: assert property (@(posedge clk) disable iff (rst)
    fire && emit && emit_kind == KIND_LONG |-> long_press_enable)
    else $error("long press reported in edge mode");

  // the hold counter never goes past one above the largest threshold
  a_hold_bound: assert property (@(posedge clk) disable iff (rst)
    hold_count <= HOLD_W'(17'h10000))
    else $error("hold counter out of range");

  // edge mode never reports an empty bitmap
  a_edge_nonempty: assert property (@(posedge clk) disable iff (rst)
    fire && emit && !long_press_enable |-> emit_keys != '0)
    else $error("empty bitmap reported in edge mode");

  // a result is loaded only when the output side has room
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(held_keys) && $stable(hold_count))
    else $error("state changed while the result was stalled");

endmodule

>>> verif/tb_key_short_long_press_detector.sv
// testbench for the key short / long press detector: random scans checked against a predictor
`timescale 1ns / 100ps

module tb_key_short_long_press_detector;
  import kslpd_pkg::*;

  // no-progress limit in cycles
  localparam int STALL_LIMIT = 2000;
  // random items per segment
  localparam int SEGMENT_ITEMS = 150;
  // register index outside the register list
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] keys;
    logic             kind;
  } press_event_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [KEY_W-1:0]       pressed_keys = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [KEY_W-1:0]       event_keys;
  logic                   press_kind;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // scans waiting to be driven and press events waiting to come out
  logic [KEY_W-1:0] pending_scans[$];
  press_event_t     expected_presses[$];
  press_event_t     oldest_press;

  // predictor copy of the configuration
  logic                  long_mode = RESET_LONG_PRESS_ENABLE;
  logic [CFG_DATA_W-1:0] long_limit = RESET_LONG_PRESS_TICKS;
  logic [CFG_DATA_W-1:0] timeout_limit = RESET_HOLD_TIMEOUT_TICKS;

  // predictor copy of the press state
  logic [KEY_W-1:0]  last_keys = '0;
  logic [HOLD_W-1:0] hold_ticks = '0;
  logic              long_sent = 1'b0;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;

  key_short_long_press_detector dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pressed_keys (pressed_keys),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_keys   (event_keys),
    .press_kind   (press_kind),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // update the press state for one accepted scan and queue any event it causes
  function automatic void predict_press(input logic [KEY_W-1:0] raw_keys);
    logic [KEY_W-1:0] keys;
    press_event_t     ev;
    keys = raw_keys & KEY_MASK;
    if (long_mode) begin
      if (hold_ticks > HOLD_W'(timeout_limit)) begin
        hold_ticks = '0;
      end else if (hold_ticks > HOLD_W'(long_limit)) begin
        if (!long_sent) begin
          ev.keys = last_keys;
          ev.kind = KIND_LONG;
          expected_presses.push_back(ev);
          long_sent = 1'b1;
        end else if (keys == '0) begin
          // release after a long press rearms
          last_keys = '0;
          hold_ticks = '0;
          long_sent = 1'b0;
        end
      end else if (keys != last_keys) begin
        if (keys == '0) begin
          ev.keys = last_keys;
          ev.kind = KIND_SHORT;
          expected_presses.push_back(ev);
        end
        last_keys = keys;
        hold_ticks = '0;
      end else if (keys != '0) begin
        hold_ticks = hold_ticks + 1'b1;
      end
    end else if (keys != last_keys) begin
      // edge mode: every new non-empty bitmap is a short press
      if (keys != '0) begin
        ev.keys = keys;
        ev.kind = KIND_SHORT;
        expected_presses.push_back(ev);
      end
      last_keys = keys;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) begin
      $display("[%0t] MISMATCH %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // driver: one scan item per handshake
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_press(pressed_keys);
      end
      if (!in_valid || in_ready) begin
        if (pending_scans.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          pressed_keys <= pending_scans.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each press event with the oldest expected one
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_presses.size() == 0) begin
          report_mismatch($sformatf("unexpected event keys=%h kind=%b", event_keys, press_kind));
        end else begin
          oldest_press = expected_presses.pop_front();
          if (event_keys !== oldest_press.keys) begin
            report_mismatch($sformatf("event_keys got %h want %h", event_keys,
                                      oldest_press.keys));
          end
          if (press_kind !== oldest_press.kind) begin
            report_mismatch($sformatf("press_kind got %b want %b (keys %h)", press_kind,
                                      oldest_press.kind, oldest_press.keys));
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // write all registers, plus one write to an unused index
  task automatic set_config(input logic en, input logic [CFG_DATA_W-1:0] lim,
                            input logic [CFG_DATA_W-1:0] tmo);
    logic [CFG_INDEX_W-1:0] regs[4];
    logic [CFG_DATA_W-1:0]  vals[4];
    regs[0] = REG_LONG_PRESS_ENABLE;
    regs[1] = REG_LONG_PRESS_TICKS;
    regs[2] = REG_HOLD_TIMEOUT_TICKS;
    regs[3] = REG_UNUSED;
    // upper bits of the enable word are junk and must be dropped
    vals[0] = (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)) | CFG_DATA_W'(en);
    vals[1] = lim;
    vals[2] = tmo;
    vals[3] = CFG_DATA_W'($urandom);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (regs[i])
        REG_LONG_PRESS_ENABLE:  long_mode = vals[i][0];
        REG_LONG_PRESS_TICKS:   long_limit = vals[i];
        REG_HOLD_TIMEOUT_TICKS: timeout_limit = vals[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // wait until every scan is taken and every event is out, then let the pipe empty
  task automatic wait_idle();
    while (pending_scans.size() != 0 || in_valid || expected_presses.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic push_hold(input logic [KEY_W-1:0] keys, input int count);
    repeat (count) pending_scans.push_back(keys);
  endtask

  // one press: hold a bitmap, maybe change it while held, then release; or line noise
  task automatic add_press_burst(input int lim);
    logic [KEY_W-1:0] keys;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      repeat ($urandom_range(1, 3)) begin
        pending_scans.push_back(($urandom_range(0, 3) == 0) ? '0 : KEY_W'($urandom));
      end
    end else begin
      if (roll < 50) begin
        keys = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
      end else if (roll < 58) begin
        keys = '1;
      end else begin
        keys = KEY_W'($urandom_range(1, 65535));
      end
      push_hold(keys, $urandom_range(1, lim + 4));
      if ($urandom_range(0, 3) == 0) begin
        push_hold(KEY_W'($urandom_range(1, 65535)), $urandom_range(1, lim + 2));
      end
      push_hold('0, $urandom_range(1, 3));
    end
  endtask

  initial begin
    logic                  seg_en;
    logic [CFG_DATA_W-1:0] seg_lim;
    logic [CFG_DATA_W-1:0] seg_tmo;
    int                    burst_lim;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: releases report the held keys as short presses
    pending_scans = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'h0000};
    wait_idle();

    // low threshold: long press once, nothing while still held, rearm on release
    set_config(1'b1, 16'd2, 16'd6);
    push_hold(16'h5555, 6);
    push_hold(16'h0000, 1);
    push_hold(16'hA5A5, 1);
    push_hold(16'h0000, 1);
    wait_idle();

    // timeout below the threshold: counter keeps clearing, no long press
    set_config(1'b1, 16'd6, 16'd2);
    push_hold(16'h0F0F, 6);
    push_hold(16'h0000, 1);
    wait_idle();

    // edge mode: repeats and empty scans give nothing
    set_config(1'b0, 16'd6, 16'd2);
    pending_scans = '{16'h0003, 16'h0003, 16'h0000, 16'h0007, 16'hFFFF, 16'h0000};
    wait_idle();

    // mode change keeps the count, so a long press can carry an empty bitmap
    set_config(1'b1, 16'd1000, 16'd2000);
    push_hold(16'hC3C3, 20);
    wait_idle();
    set_config(1'b0, 16'd1000, 16'd2000);
    pending_scans = '{16'h0000, 16'h0F00, 16'h0000};
    wait_idle();
    set_config(1'b1, 16'd5, 16'd2000);
    push_hold(16'h0000, 2);
    wait_idle();

    // full-scale settings: a hold far under the threshold gives only the release
    set_config(1'b1, 16'hFFFF, 16'hFFFF);
    push_hold(16'h1234, 40);
    push_hold(16'h0000, 1);
    wait_idle();

    // random segments, idling pattern changes with each one
    for (int seg = 0; seg < 10; seg++) begin
      case (seg)
        0: begin seg_en = 1'b1; seg_lim = 16'd0;   seg_tmo = 16'd0;     end
        1: begin seg_en = 1'b1; seg_lim = 16'd0;   seg_tmo = 16'hFFFF;  end
        2: begin seg_en = 1'b1; seg_lim = 16'd100; seg_tmo = 16'd1000;  end
        3: begin seg_en = 1'b0; seg_lim = 16'd3;   seg_tmo = 16'd9;     end
        default: begin
          seg_en = ($urandom_range(0, 4) != 0);
          seg_lim = CFG_DATA_W'($urandom_range(0, 12));
          seg_tmo = ($urandom_range(0, 3) == 0) ? 16'hFFFF : CFG_DATA_W'($urandom_range(0, 20));
        end
      endcase
      case (seg % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 74; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 74; end
        default: begin in_idle_pct = 36; out_stall_pct = 36; end
      endcase
      set_config(seg_en, seg_lim, seg_tmo);
      burst_lim = (seg_lim > 120) ? 120 : int'(seg_lim);
      while (pending_scans.size() < SEGMENT_ITEMS) add_press_burst(burst_lim);
      wait_idle();
    end

    if (mismatch_count == 0 && expected_presses.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
design/kslpd_pkg.sv
design/key_short_long_press_detector.sv
verif/tb_key_short_long_press_detector.sv
